// ----- rtl/core/cpa_pkg.sv -----
// Shared constants, codes and types for the contiguous page allocator.
// No dependencies; imported by cpa_word_scan and contiguous_page_allocator.
`timescale 1ns / 1ps

package cpa_pkg;

   localparam int NUM_PAGES   = 256;
   localparam int WORD_BITS   = 16;
   localparam int NUM_WORDS   = NUM_PAGES / WORD_BITS;
   localparam int PAGE_IDX_W  = $clog2(NUM_PAGES);
   localparam int BIT_IDX_W   = $clog2(WORD_BITS);
   localparam int WORD_IDX_W  = PAGE_IDX_W - BIT_IDX_W;
   localparam int RUN_W       = $clog2(NUM_PAGES + 1);
   localparam int PAGE_SHIFT  = 12;
   localparam int ADDR_W      = 32;
   localparam int COUNT_W     = 16;
   localparam int STATUS_W    = 3;

   localparam logic [ADDR_W:0]   POOL_SPAN = (ADDR_W + 1)'(NUM_PAGES * 4096);
   localparam logic [ADDR_W-1:0] POOL_BASE_RESET =
      ADDR_W'(32'h0100_0000 - NUM_PAGES * 4096);

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
   localparam logic [STATUS_W-1:0] ST_ZERO_COUNT   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NO_RUN       = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NULL_ADDR    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_OUT_OF_RANGE = 3'd4;
   localparam logic [STATUS_W-1:0] ST_DOUBLE_FREE  = 3'd5;

   typedef struct packed {
      logic                  hit;
      logic [PAGE_IDX_W-1:0] start;
      logic [RUN_W-1:0]      run;
      logic [PAGE_IDX_W-1:0] run_start;
   } scan_res_type;

endpackage

// ----- rtl/core/cpa_word_scan.sv -----
// Evaluates one used-map word for the first-fit search, extending the free run
// carried in from lower words. Depends on cpa_pkg.
`timescale 1ns / 1ps

module cpa_word_scan
   import cpa_pkg::*;
(
   input  logic [WORD_BITS-1:0]  used_word,
   input  logic [WORD_IDX_W-1:0] word_idx,
   input  logic [RUN_W-1:0]      carry_run,
   input  logic [PAGE_IDX_W-1:0] carry_start,
   input  logic [RUN_W-1:0]      count,
   output scan_res_type          result
);

   logic [RUN_W-1:0]      len      [WORD_BITS];
   logic [PAGE_IDX_W-1:0] start_at [WORD_BITS];

   always_comb begin
      for (int k = 0; k < WORD_BITS; k++) begin
         logic                 all_free;
         logic [BIT_IDX_W-1:0] last_used;
         all_free  = 1'b1;
         last_used = '0;
         for (int j = 0; j <= k; j++) begin
            if (used_word[j]) begin
               all_free  = 1'b0;
               last_used = BIT_IDX_W'(j);
            end
         end
         if (all_free) begin
            len[k] = carry_run + RUN_W'(k + 1);
            if (carry_run != '0) begin
               start_at[k] = carry_start;
            end else begin
               start_at[k] = {word_idx, {BIT_IDX_W{1'b0}}};
            end
         end else begin
            len[k]      = RUN_W'(k) - RUN_W'(last_used);
            start_at[k] = {word_idx, BIT_IDX_W'(last_used + 1'b1)};
         end
      end
   end

   always_comb begin
      result.hit       = 1'b0;
      result.start     = '0;
      result.run       = len[WORD_BITS-1];
      result.run_start = start_at[WORD_BITS-1];
      for (int k = WORD_BITS - 1; k >= 0; k--) begin
         if (!used_word[k] && (len[k] >= count)) begin
            result.hit   = 1'b1;
            result.start = start_at[k];
         end
      end
   end

endmodule

// ----- rtl/core/contiguous_page_allocator.sv -----
// First-fit allocator over a bitmap of page used bits kept in a word memory.
// Depends on cpa_pkg and cpa_word_scan.
//
//   channel  direction  contents
//   req_*    in         tuser command, tdata page_count and free_address
//   rsp_*    out        tdata status and alloc_address
//   csr_*    in         pool_base register write
//
// An allocate scans used-map words in order (up to 16) until a run fits, then
// rewrites each word it marks; a free clears the page's bit if set; a rejected
// command goes straight to done. Reset is synchronous and marks every page
// free through per-word valid bits, with no clearing pass. A new item is taken
// while a result waits in the output register; the next result waits for it.
`timescale 1ns / 1ps

module contiguous_page_allocator
   import cpa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // page_count[15:0], free_address[47:16]
   input  logic        req_tuser,   // command[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // status[2:0], alloc_address[34:3], zero[39:35]
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_SCAN     = 3'd1;
   localparam logic [2:0] S_MARK_RD  = 3'd2;
   localparam logic [2:0] S_MARK_WR  = 3'd3;
   localparam logic [2:0] S_FREE_CHK = 3'd4;
   localparam logic [2:0] S_DONE     = 3'd5;

   logic [2:0]            state_ff, state_in;
   logic [ADDR_W-1:0]     pool_base_ff;
   logic [RUN_W-1:0]      count_ff, count_in;
   logic [WORD_IDX_W-1:0] word_ff, word_in;
   logic [RUN_W-1:0]      run_ff, run_in;
   logic [PAGE_IDX_W-1:0] run_start_ff, run_start_in;
   logic [PAGE_IDX_W-1:0] start_ff, start_in;
   logic [PAGE_IDX_W-1:0] page_ff, page_in;
   logic [STATUS_W-1:0]   res_status_ff, res_status_in;
   logic [ADDR_W-1:0]     res_addr_ff, res_addr_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   rsp_status_ff;
   logic [ADDR_W-1:0]     rsp_addr_ff;

   logic [WORD_BITS-1:0]  used_mem [NUM_WORDS];
   logic [NUM_WORDS-1:0]  row_valid_ff;
   logic [WORD_BITS-1:0]  mem_rdata_ff;
   logic                  rd_valid_ff;
   logic                  mem_rd_en;
   logic [WORD_IDX_W-1:0] mem_rd_addr;
   logic                  mem_wr_en;
   logic [WORD_IDX_W-1:0] mem_wr_addr;
   logic [WORD_BITS-1:0]  mem_wr_data;
   logic [WORD_BITS-1:0]  used_word;

   logic                  accept;
   logic [COUNT_W-1:0]    req_count;
   logic [ADDR_W-1:0]     req_addr;
   logic [ADDR_W:0]       free_off;
   logic [ADDR_W:0]       pool_end;
   logic [PAGE_IDX_W-1:0] last_page;
   logic [WORD_BITS-1:0]  mark_mask;
   logic                  load_rsp;
   scan_res_type          scan_res;

   assign req_count = req_tdata[COUNT_W-1:0];
   assign req_addr  = req_tdata[COUNT_W +: ADDR_W];
   assign req_tready = (state_ff == S_IDLE);
   assign accept    = req_tvalid && req_tready;
   assign free_off  = {1'b0, req_addr} - {1'b0, pool_base_ff};
   assign pool_end  = {1'b0, pool_base_ff} + POOL_SPAN;
   assign used_word = rd_valid_ff ? mem_rdata_ff : '0;
   assign last_page = PAGE_IDX_W'(({1'b0, start_ff} + count_ff) - 1'b1);

   cpa_word_scan u_scan (
      .used_word   (used_word),
      .word_idx    (word_ff),
      .carry_run   (run_ff),
      .carry_start (run_start_ff),
      .count       (count_ff),
      .result      (scan_res)
   );

   always_comb begin
      for (int b = 0; b < WORD_BITS; b++) begin
         logic [PAGE_IDX_W-1:0] idx;
         idx          = {word_ff, BIT_IDX_W'(b)};
         mark_mask[b] = (idx >= start_ff) && (idx <= last_page);
      end
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      word_in       = word_ff;
      run_in        = run_ff;
      run_start_in  = run_start_ff;
      start_in      = start_ff;
      page_in       = page_ff;
      res_status_in = res_status_ff;
      res_addr_in   = res_addr_ff;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = word_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = word_ff;
      mem_wr_data   = used_word | mark_mask;
      load_rsp      = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               res_addr_in  = '0;
               word_in      = '0;
               run_in       = '0;
               run_start_in = '0;
               count_in     = RUN_W'(req_count);
               page_in      = free_off[PAGE_SHIFT +: PAGE_IDX_W];
               if (req_tuser == CMD_ALLOC) begin
                  if (req_count == '0) begin
                     res_status_in = ST_ZERO_COUNT;
                     state_in      = S_DONE;
                  end else if (req_count > COUNT_W'(NUM_PAGES)) begin
                     res_status_in = ST_NO_RUN;
                     state_in      = S_DONE;
                  end else begin
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = '0;
                     state_in    = S_SCAN;
                  end
               end else begin
                  if (req_addr == '0) begin
                     res_status_in = ST_NULL_ADDR;
                     state_in      = S_DONE;
                  end else if ((req_addr < pool_base_ff) ||
                               ({1'b0, req_addr} >= pool_end)) begin
                     res_status_in = ST_OUT_OF_RANGE;
                     state_in      = S_DONE;
                  end else begin
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = free_off[PAGE_SHIFT + BIT_IDX_W +: WORD_IDX_W];
                     state_in    = S_FREE_CHK;
                  end
               end
            end
         end
         S_SCAN: begin
            if (scan_res.hit) begin
               start_in = scan_res.start;
               word_in  = scan_res.start[PAGE_IDX_W-1 -: WORD_IDX_W];
               state_in = S_MARK_RD;
            end else if (word_ff == WORD_IDX_W'(NUM_WORDS - 1)) begin
               res_status_in = ST_NO_RUN;
               state_in      = S_DONE;
            end else begin
               mem_rd_en    = 1'b1;
               mem_rd_addr  = word_ff + 1'b1;
               word_in      = word_ff + 1'b1;
               run_in       = scan_res.run;
               run_start_in = scan_res.run_start;
            end
         end
         S_MARK_RD: begin
            mem_rd_en = 1'b1;
            state_in  = S_MARK_WR;
         end
         S_MARK_WR: begin
            mem_wr_en = 1'b1;
            if (word_ff == last_page[PAGE_IDX_W-1 -: WORD_IDX_W]) begin
               res_status_in = ST_OK;
               res_addr_in   = pool_base_ff + (ADDR_W'(start_ff) << PAGE_SHIFT);
               state_in      = S_DONE;
            end else begin
               word_in  = word_ff + 1'b1;
               state_in = S_MARK_RD;
            end
         end
         S_FREE_CHK: begin
            mem_wr_addr = page_ff[PAGE_IDX_W-1 -: WORD_IDX_W];
            mem_wr_data = used_word & ~(WORD_BITS'(1) << page_ff[BIT_IDX_W-1:0]);
            if (used_word[page_ff[BIT_IDX_W-1:0]]) begin
               mem_wr_en     = 1'b1;
               res_status_in = ST_OK;
            end else begin
               res_status_in = ST_DOUBLE_FREE;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               load_rsp = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         used_mem[mem_wr_addr] <= mem_wr_data;
      end
      if (mem_rd_en) begin
         mem_rdata_ff <= used_mem[mem_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pool_base_ff <= POOL_BASE_RESET;
         rsp_valid_ff <= 1'b0;
         row_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            pool_base_ff <= csr_wr_data;
         end
         if (mem_wr_en) begin
            row_valid_ff[mem_wr_addr] <= 1'b1;
         end
         if (mem_rd_en) begin
            rd_valid_ff <= row_valid_ff[mem_rd_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      count_ff      <= count_in;
      word_ff       <= word_in;
      run_ff        <= run_in;
      run_start_ff  <= run_start_in;
      start_ff      <= start_in;
      page_ff       <= page_in;
      res_status_ff <= res_status_in;
      res_addr_ff   <= res_addr_in;
      if (load_rsp) begin
         rsp_status_ff <= res_status_ff;
         rsp_addr_ff   <= res_addr_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_addr_ff, rsp_status_ff};

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != S_IDLE))
      else $error("accepted item did not start work");

   a_write_only_when_updating: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> ((state_ff == S_MARK_WR) || (state_ff == S_FREE_CHK)))
      else $error("used map written outside an update step");

   a_error_has_no_address: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != ST_OK)) |-> (rsp_addr_ff == '0))
      else $error("failed command returned an address");

   a_load_only_when_free: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !load_rsp)
      else $error("result overwrote a pending result");

endmodule
